@@ sv/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared sizes, codes and types of the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int MAX_JOBS   = 16;
    localparam int BURST_BITS = 16;
    localparam int TIME_BITS  = 32;

    localparam int IDX_W      = $clog2(MAX_JOBS);
    localparam int TREE_LEAVES = 1 << IDX_W;
    localparam int ORDER_BITS = 32;
    localparam int ID_BITS    = 16;
    localparam int LEFT_OUT_BITS = 16;
    localparam int TIME_OUT_BITS = 32;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_ADMIT    = 3'd0,
        ST_REJ_FULL = 3'd1,
        ST_REJ_ZERO = 3'd2,
        ST_RAN      = 3'd3,
        ST_IDLE     = 3'd4
    } status_t;

    // candidate in the selection tree
    typedef struct packed {
        logic                  valid;
        logic [BURST_BITS-1:0] left;
        logic [ORDER_BITS-1:0] order;
        logic [IDX_W-1:0]      idx;
    } cand_t;

    // table update request for one item
    typedef struct packed {
        logic                  admit;
        logic                  run;
        logic [IDX_W-1:0]      idx;
        logic [ID_BITS-1:0]    id;
        logic [BURST_BITS-1:0] burst;
        logic [ORDER_BITS-1:0] order;
    } upd_t;

    // table view seen by the control path
    typedef struct packed {
        logic               full;
        logic [IDX_W-1:0]   free_idx;
        cand_t              pick;
        logic [ID_BITS-1:0] pick_id;
    } view_t;

    // a is the lower-index side and wins when both left and order tie
    function automatic cand_t pick_min(input cand_t a, input cand_t b);
        logic take_b;
        take_b = b.valid && (!a.valid || (b.left < a.left) ||
                 ((b.left == a.left) && (b.order < a.order)));
        return take_b ? b : a;
    endfunction

endpackage

@@ sv/srtf_if.sv @@
// ----------------------------------------------------------------------------
// srtf_req_if / srtf_rsp_if
// Valid/ready channels for scheduler items and results.
// ----------------------------------------------------------------------------
interface srtf_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [srtf_pkg::ID_BITS-1:0]        job_id;
    logic [15:0]                         burst_len;

    modport source (output valid, output kind, output job_id, output burst_len,
                    input ready);
    modport sink   (input valid, input kind, input job_id, input burst_len,
                    output ready);
endinterface

interface srtf_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          status;
    logic [srtf_pkg::ID_BITS-1:0]        ran_id;
    logic [srtf_pkg::LEFT_OUT_BITS-1:0]  left_after;
    logic                                done_res;
    logic [srtf_pkg::TIME_OUT_BITS-1:0]  end_time;

    modport source (output valid, output status, output ran_id, output left_after,
                    output done_res, output end_time, input ready);
    modport sink   (input valid, input status, input ran_id, input left_after,
                    input done_res, input end_time, output ready);
endinterface

@@ sv/shortest_remaining_time_scheduler.sv @@
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive shortest-remaining-time job scheduler with admit and tick items.
// ----------------------------------------------------------------------------
//   channel | role   | payload
//   req     | sink   | kind, job_id, burst_len
//   rsp     | source | status, ran_id, left_after, done_res, end_time
//
// one item per cycle while rsp is ready; rsp valid follows the req beat via
// (input register, one pass through the slot tree, result register)
// the 16-slot minimum tree and free-slot search set the longest logic path
// reset empties the job table and clears the time and arrival counters
// a stalled rsp holds the input register, and req stalls once that fills
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler
(
    input  logic              clk,
    input  logic              rst_n,
    srtf_req_if.sink          req,
    srtf_rsp_if.source        rsp
);

    logic                            in_valid_reg;
    logic                            kind_reg;
    logic [srtf_pkg::ID_BITS-1:0]    id_reg;
    logic [srtf_pkg::BURST_BITS-1:0] burst_reg;

    logic [srtf_pkg::TIME_BITS-1:0]  now_reg;
    logic [srtf_pkg::TIME_BITS-1:0]  now_next;
    logic [srtf_pkg::ORDER_BITS-1:0] order_reg;
    logic [srtf_pkg::ORDER_BITS-1:0] order_next;

    logic                                 out_valid_reg;
    srtf_pkg::status_t                    status_reg;
    srtf_pkg::status_t                    status_next;
    logic [srtf_pkg::ID_BITS-1:0]         ran_id_reg;
    logic [srtf_pkg::ID_BITS-1:0]         ran_id_next;
    logic [srtf_pkg::LEFT_OUT_BITS-1:0]   left_reg;
    logic [srtf_pkg::LEFT_OUT_BITS-1:0]   left_next;
    logic                                 done_reg;
    logic                                 done_next;
    logic [srtf_pkg::TIME_OUT_BITS-1:0]   time_reg;
    logic [srtf_pkg::TIME_OUT_BITS-1:0]   time_next;

    logic                            advance;
    logic [srtf_pkg::TIME_BITS-1:0]  now_inc;
    logic [srtf_pkg::BURST_BITS-1:0] pick_left_new;

    srtf_pkg::upd_t  upd;
    srtf_pkg::view_t view;

    srtf_table u_table
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .view  (view)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    assign now_inc = (now_reg == '1) ? now_reg : now_reg + srtf_pkg::TIME_BITS'(1);
    assign pick_left_new = view.pick.left - srtf_pkg::BURST_BITS'(1);

    always_comb
    begin
        upd         = '0;
        upd.id      = id_reg;
        upd.burst   = burst_reg;
        upd.order   = order_reg;
        now_next    = now_reg;
        order_next  = order_reg;
        status_next = srtf_pkg::ST_IDLE;
        ran_id_next = '0;
        left_next   = '0;
        done_next   = 1'b0;
        time_next   = srtf_pkg::TIME_OUT_BITS'(now_reg);

        if (kind_reg == srtf_pkg::KIND_ADMIT)
        begin
            if (burst_reg == '0)
            begin
                status_next = srtf_pkg::ST_REJ_ZERO;
            end
            else if (view.full)
            begin
                status_next = srtf_pkg::ST_REJ_FULL;
            end
            else
            begin
                status_next = srtf_pkg::ST_ADMIT;
                upd.admit   = advance;
                upd.idx     = view.free_idx;
                ran_id_next = id_reg;
                left_next   = srtf_pkg::LEFT_OUT_BITS'(burst_reg);
                order_next  = (order_reg == '1) ? order_reg
                                                : order_reg + srtf_pkg::ORDER_BITS'(1);
            end
        end
        else
        begin
            now_next  = now_inc;
            time_next = srtf_pkg::TIME_OUT_BITS'(now_inc);
            if (view.pick.valid)
            begin
                status_next = srtf_pkg::ST_RAN;
                upd.run     = advance;
                upd.idx     = view.pick.idx;
                ran_id_next = view.pick_id;
                left_next   = srtf_pkg::LEFT_OUT_BITS'(pick_left_new);
                done_next   = (pick_left_new == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            now_reg       <= '0;
            order_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                now_reg       <= now_next;
                order_reg     <= order_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            kind_reg  <= req.kind;
            id_reg    <= req.job_id;
            burst_reg <= srtf_pkg::BURST_BITS'(req.burst_len);
        end
        if (advance)
        begin
            status_reg <= status_next;
            ran_id_reg <= ran_id_next;
            left_reg   <= left_next;
            done_reg   <= done_next;
            time_reg   <= time_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.ran_id     = ran_id_reg;
    assign rsp.left_after = left_reg;
    assign rsp.done_res   = done_reg;
    assign rsp.end_time   = time_reg;

endmodule

@@ sv/srtf_pick.sv @@
// ----------------------------------------------------------------------------
// srtf_pick
// Minimum tree over the job slots: least remaining time, then earliest arrival.
// ----------------------------------------------------------------------------
module srtf_pick
(
    input  logic [srtf_pkg::MAX_JOBS-1:0]   valid,
    input  logic [srtf_pkg::BURST_BITS-1:0] left  [srtf_pkg::MAX_JOBS],
    input  logic [srtf_pkg::ORDER_BITS-1:0] order [srtf_pkg::MAX_JOBS],
    output srtf_pkg::cand_t                 pick
);

    // heap layout: leaves start at TREE_LEAVES-1, root at 0
    srtf_pkg::cand_t node [2*srtf_pkg::TREE_LEAVES-1];

    always_comb
    begin
        for (int i = 0; i < srtf_pkg::TREE_LEAVES; i++)
        begin
            if (i < srtf_pkg::MAX_JOBS)
            begin
                node[srtf_pkg::TREE_LEAVES-1+i].valid = valid[i];
                node[srtf_pkg::TREE_LEAVES-1+i].left  = left[i];
                node[srtf_pkg::TREE_LEAVES-1+i].order = order[i];
                node[srtf_pkg::TREE_LEAVES-1+i].idx   = srtf_pkg::IDX_W'(i);
            end
            else
            begin
                node[srtf_pkg::TREE_LEAVES-1+i] = '0;
            end
        end
        for (int n = srtf_pkg::TREE_LEAVES-2; n >= 0; n--)
        begin
            node[n] = srtf_pkg::pick_min(node[2*n+1], node[2*n+2]);
        end
    end

    assign pick = node[0];

endmodule

@@ sv/srtf_table.sv @@
// ----------------------------------------------------------------------------
// srtf_table
// Job slot storage with free-slot search, job selection and per-item update.
// ----------------------------------------------------------------------------
module srtf_table
(
    input  logic                clk,
    input  logic                rst_n,
    input  srtf_pkg::upd_t      upd,
    output srtf_pkg::view_t     view
);

    logic [srtf_pkg::MAX_JOBS-1:0]   slot_valid_reg;
    logic [srtf_pkg::ID_BITS-1:0]    slot_id_reg    [srtf_pkg::MAX_JOBS];
    logic [srtf_pkg::BURST_BITS-1:0] slot_left_reg  [srtf_pkg::MAX_JOBS];
    logic [srtf_pkg::ORDER_BITS-1:0] slot_order_reg [srtf_pkg::MAX_JOBS];

    srtf_pkg::cand_t                 pick;
    logic [srtf_pkg::BURST_BITS-1:0] run_left;

    srtf_pick u_pick
    (
        .valid (slot_valid_reg),
        .left  (slot_left_reg),
        .order (slot_order_reg),
        .pick  (pick)
    );

    // lowest free slot
    always_comb
    begin
        view.full     = 1'b1;
        view.free_idx = '0;
        for (int k = srtf_pkg::MAX_JOBS-1; k >= 0; k--)
        begin
            if (!slot_valid_reg[k])
            begin
                view.full     = 1'b0;
                view.free_idx = srtf_pkg::IDX_W'(k);
            end
        end
        view.pick    = pick;
        view.pick_id = slot_id_reg[pick.idx];
    end

    // valid entries always hold a nonzero remaining time
    assign run_left = slot_left_reg[upd.idx] - srtf_pkg::BURST_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (upd.admit)
        begin
            slot_valid_reg[upd.idx] <= 1'b1;
        end
        else if (upd.run && (run_left == '0))
        begin
            slot_valid_reg[upd.idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.admit)
        begin
            slot_id_reg[upd.idx]    <= upd.id;
            slot_left_reg[upd.idx]  <= upd.burst;
            slot_order_reg[upd.idx] <= upd.order;
        end
        else if (upd.run)
        begin
            slot_left_reg[upd.idx]  <= run_left;
        end
    end

endmodule
